### design/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// shared types, widths and constants of the pid heater duty controller
// ----------------------------------------------------------------------------
package phd_pkg;

    localparam int TEMP_W     = 14;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 7;
    localparam int SUM_W      = 48;
    localparam int ACC_W      = 64;
    localparam int ERR_W      = TEMP_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int MAG_W      = ERR_W;
    localparam int FRAC_W     = 12;
    localparam int QUO_W      = MAG_W + FRAC_W;
    localparam int REM_W      = GAIN_W + 1;
    localparam int DQ_W       = QUO_W + REM_W;
    localparam int DERIV_W    = QUO_W + 1;
    localparam int MUL_STEPS  = GAIN_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int DUTY_SHIFT = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST     = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST    = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST    = 16'd0;
    localparam logic [GAIN_W-1:0] SAMPLE_PERIOD_RST = 16'd4096;
    localparam logic [GAIN_W-1:0] PERIOD_MIN        = 16'd1;

    localparam logic signed [ACC_W-1:0] ITERM_LIMIT  = 64'sh1000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] DUTY_MAX_FIX = 64'sd1677721600;
    localparam logic [DUTY_W-1:0]       DUTY_MAX     = 7'd100;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [GAIN_W-1:0] period;
    } gains_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_DABS,
        ST_DIV,
        ST_DNEG,
        ST_IPMUL,
        ST_ISUM,
        ST_IMUL,
        ST_ISAT,
        ST_PMUL,
        ST_DMUL,
        ST_CLAMP
    } phd_state_t;

endpackage

### design/phd_alu.sv
// ----------------------------------------------------------------------------
// phd_alu
// shared 64-bit adder / subtractor used by the arithmetic steps of the sequencer
// ----------------------------------------------------------------------------
module phd_alu (
    input  phd_pkg::alu_req_t           req,
    output logic [phd_pkg::ACC_W-1:0]   res
);
    import phd_pkg::*;

    logic             sub;
    logic [ACC_W-1:0] b_eff;

    always_comb
    begin
        case (req.op)
            ALU_ADD: sub = 1'b0;
            ALU_SUB: sub = 1'b1;
            default: sub = 1'b0;
        endcase
    end

    assign b_eff = sub ? ~req.b : req.b;
    assign res   = req.a + b_eff + ACC_W'(sub);

endmodule

### design/phd_core.sv
// ----------------------------------------------------------------------------
// phd_core
// sequencer and datapath registers: error, divider, shift-add multiplies,
// integral saturation and output clamp; the arithmetic steps use one shared adder
// ----------------------------------------------------------------------------
module phd_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [phd_pkg::TEMP_W-1:0]    setpoint_temp,
    input  logic [phd_pkg::TEMP_W-1:0]    measured_temp,
    input  phd_pkg::gains_t               gains,
    input  logic                          out_free,
    output logic                          idle,
    output logic                          done,
    output logic [phd_pkg::DUTY_W-1:0]    duty_percent
);
    import phd_pkg::*;

    phd_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [ERR_W-1:0]   last_reg, last_next;
    logic [TEMP_W-1:0]  sp_reg, sp_next;
    logic [TEMP_W-1:0]  pv_reg, pv_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [DIFF_W-1:0]  diff_reg, diff_next;
    logic [DQ_W-1:0]    dq_reg, dq_next;
    logic [DERIV_W-1:0] deriv_reg, deriv_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [GAIN_W-1:0]  mplier_reg, mplier_next;

    alu_req_t           alu_req;
    logic [ACC_W-1:0]   alu_res;

    logic               last_mul;
    logic               last_div;
    logic [DQ_W-1:0]    dq_shift;
    logic [ACC_W-1:0]   err_ext;
    logic [ACC_W-1:0]   diff_ext;
    logic [ACC_W-1:0]   p_operand;
    logic [ACC_W-1:0]   d_operand;
    logic [SUM_W-1:0]   sum_sat;
    logic               sum_ovf;

    phd_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign last_mul  = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign last_div  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign dq_shift  = {dq_reg[DQ_W-2:0], 1'b0};
    assign err_ext   = {{(ACC_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign diff_ext  = {{(ACC_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
    assign p_operand = {{(ACC_W-ERR_W-FRAC_W){err_reg[ERR_W-1]}}, err_reg, {FRAC_W{1'b0}}};
    assign d_operand = {{(ACC_W-DERIV_W-FRAC_W){deriv_reg[DERIV_W-1]}}, deriv_reg,
                        {FRAC_W{1'b0}}};

    // integral overflow: upper bits of the wide sum disagree with the sign
    assign sum_ovf = !((&alu_res[ACC_W-1:SUM_W-1]) || !(|alu_res[ACC_W-1:SUM_W-1]));
    assign sum_sat = sum_ovf ? (alu_res[ACC_W-1] ? SUM_MIN : SUM_MAX) : alu_res[SUM_W-1:0];

    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        if ($signed(acc_reg) < 0)
        begin
            duty_percent = '0;
        end
        else if ($signed(acc_reg) > DUTY_MAX_FIX)
        begin
            duty_percent = DUTY_MAX;
        end
        else
        begin
            duty_percent = acc_reg[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_ERR;
            ST_ERR:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_DABS;
            ST_DABS:  state_next = ST_DIV;
            ST_DIV:   if (last_div) state_next = ST_DNEG;
            ST_DNEG:  state_next = ST_IPMUL;
            ST_IPMUL: if (last_mul) state_next = ST_ISUM;
            ST_ISUM:  state_next = ST_IMUL;
            ST_IMUL:  if (last_mul) state_next = ST_ISAT;
            ST_ISAT:  state_next = ST_PMUL;
            ST_PMUL:  if (last_mul) state_next = ST_DMUL;
            ST_DMUL:  if (last_mul) state_next = ST_CLAMP;
            ST_CLAMP: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        sp_next     = sp_reg;
        pv_next     = pv_reg;
        err_next    = err_reg;
        diff_next   = diff_reg;
        dq_next     = dq_reg;
        deriv_next  = deriv_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        alu_req     = '{op: ALU_ADD, a: '0, b: '0};
        done        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sp_next = setpoint_temp;
                    pv_next = measured_temp;
                end
            end
            ST_ERR:
            begin
                alu_req  = '{op: ALU_SUB, a: ACC_W'(sp_reg), b: ACC_W'(pv_reg)};
                err_next = alu_res[ERR_W-1:0];
            end
            ST_DIFF:
            begin
                alu_req   = '{op: ALU_SUB, a: err_ext,
                              b: {{(ACC_W-ERR_W){last_reg[ERR_W-1]}}, last_reg}};
                diff_next = alu_res[DIFF_W-1:0];
            end
            ST_DABS:
            begin
                if (diff_reg[DIFF_W-1])
                begin
                    alu_req = '{op: ALU_SUB, a: '0, b: diff_ext};
                end
                else
                begin
                    alu_req = '{op: ALU_ADD, a: diff_ext, b: '0};
                end
                dq_next  = {{REM_W{1'b0}}, alu_res[MAG_W-1:0], {FRAC_W{1'b0}}};
                cnt_next = '0;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                alu_req = '{op: ALU_SUB, a: ACC_W'(dq_shift[DQ_W-1:QUO_W]),
                            b: ACC_W'(gains.period)};
                if (alu_res[ACC_W-1])
                begin
                    dq_next = dq_shift;
                end
                else
                begin
                    dq_next = {alu_res[REM_W-1:0], dq_shift[QUO_W-1:1], 1'b1};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DNEG:
            begin
                if (diff_reg[DIFF_W-1])
                begin
                    alu_req = '{op: ALU_SUB, a: '0, b: ACC_W'(dq_reg[QUO_W-1:0])};
                end
                else
                begin
                    alu_req = '{op: ALU_ADD, a: ACC_W'(dq_reg[QUO_W-1:0]), b: '0};
                end
                deriv_next  = alu_res[DERIV_W-1:0];
                acc_next    = '0;
                mcand_next  = err_ext;
                mplier_next = gains.period;
                cnt_next    = '0;
            end
            ST_IPMUL, ST_IMUL, ST_PMUL, ST_DMUL:
            begin
                // shift-add multiply, one multiplier bit a cycle
                alu_req     = '{op: ALU_ADD, a: acc_reg,
                                b: mplier_reg[0] ? mcand_reg : '0};
                acc_next    = alu_res;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[GAIN_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (last_mul && state_reg == ST_PMUL)
                begin
                    mcand_next  = d_operand;
                    mplier_next = gains.gain_deriv;
                    cnt_next    = '0;
                end
            end
            ST_ISUM:
            begin
                alu_req     = '{op: ALU_ADD,
                                a: {{(ACC_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg},
                                b: acc_reg};
                sum_next    = sum_sat;
                acc_next    = '0;
                mcand_next  = {{(ACC_W-SUM_W){sum_sat[SUM_W-1]}}, sum_sat};
                mplier_next = gains.gain_integ;
                cnt_next    = '0;
            end
            ST_ISAT:
            begin
                if ($signed(acc_reg) > ITERM_LIMIT)
                begin
                    acc_next = ITERM_LIMIT;
                end
                else if ($signed(acc_reg) < -ITERM_LIMIT)
                begin
                    acc_next = -ITERM_LIMIT;
                end
                mcand_next  = p_operand;
                mplier_next = gains.gain_prop;
                cnt_next    = '0;
            end
            ST_CLAMP:
            begin
                if (out_free)
                begin
                    done      = 1'b1;
                    last_next = err_reg;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sp_reg     <= sp_next;
        pv_reg     <= pv_next;
        err_reg    <= err_next;
        diff_reg   <= diff_next;
        dq_reg     <= dq_next;
        deriv_reg  <= deriv_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

### design/pid_heater_duty.sv
// ----------------------------------------------------------------------------
// pid_heater_duty
// pid heater controller with a 0..100 percent output clamp
// ----------------------------------------------------------------------------
// a new sample is taken only while the sequencer is idle, after the last is through
// steps of the sequencer, most on the single shared 64-bit adder:
//   27 quotient bits, four 16-bit multiplies and seven single steps
// a stalled result holds the sequencer in its last step
// reset: gains and sample period to defaults, integral and last error cleared
// ----------------------------------------------------------------------------
module pid_heater_duty (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // setpoint_temp, measured_temp
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // duty_percent
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [phd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [phd_pkg::GAIN_W-1:0]        cfg_data
);
    import phd_pkg::*;

    logic [GAIN_W-1:0] gain_prop_reg, gain_prop_next;
    logic [GAIN_W-1:0] gain_integ_reg, gain_integ_next;
    logic [GAIN_W-1:0] gain_deriv_reg, gain_deriv_next;
    logic [GAIN_W-1:0] period_reg, period_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    gains_t            gains;
    logic              core_idle;
    logic              core_done;
    logic [DUTY_W-1:0] core_duty;
    logic              out_free;
    logic              start;

    assign cfg_ready = 1'b1;
    assign s_tready  = core_idle;
    assign start     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, duty_reg};

    // a zero period is taken as one tick
    assign gains = '{gain_prop:  gain_prop_reg,
                     gain_integ: gain_integ_reg,
                     gain_deriv: gain_deriv_reg,
                     period:     (period_reg == '0) ? PERIOD_MIN : period_reg};

    phd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .setpoint_temp (s_tdata[TEMP_W-1:0]),
        .measured_temp (s_tdata[2*TEMP_W-1:TEMP_W]),
        .gains         (gains),
        .out_free      (out_free),
        .idle          (core_idle),
        .done          (core_done),
        .duty_percent  (core_duty)
    );

    always_comb
    begin
        gain_prop_next  = gain_prop_reg;
        gain_integ_next = gain_integ_reg;
        gain_deriv_next = gain_deriv_reg;
        period_next     = period_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_PROP:     gain_prop_next  = cfg_data;
                REG_GAIN_INTEG:    gain_integ_next = cfg_data;
                REG_GAIN_DERIV:    gain_deriv_next = cfg_data;
                REG_SAMPLE_PERIOD: period_next     = cfg_data;
                default:           period_next     = period_reg;
            endcase
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        duty_next     = duty_reg;
        if (core_done)
        begin
            m_tvalid_next = 1'b1;
            duty_next     = core_duty;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_integ_reg <= GAIN_INTEG_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
            period_reg     <= SAMPLE_PERIOD_RST;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            gain_prop_reg  <= gain_prop_next;
            gain_integ_reg <= gain_integ_next;
            gain_deriv_reg <= gain_deriv_next;
            period_reg     <= period_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
    end

endmodule
